### rtl/enr_pkg.sv
// ============================================================================
// Rotor step and map package
// Shared types and constants for the single cipher rotor block.
// ============================================================================
package enr_pkg;

   // Alphabet geometry.
   localparam int ALPHABET_SIZE = 26;
   localparam int LETTER_W      = 5;
   localparam logic [LETTER_W-1:0] LAST_LETTER = LETTER_W'(ALPHABET_SIZE - 1);

   // Request kinds.
   localparam logic [2:0] KIND_LOAD     = 3'd0;
   localparam logic [2:0] KIND_RESTART  = 3'd1;
   localparam logic [2:0] KIND_STEP     = 3'd2;
   localparam logic [2:0] KIND_FORWARD  = 3'd3;
   localparam logic [2:0] KIND_BACKWARD = 3'd4;

   // Configuration register indexes.
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 26;
   localparam logic [CSR_INDEX_W-1:0] CSR_NOTCH_MASK     = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_START_POSITION = 4'd1;

   // Request payload.
   typedef struct packed {
      logic [2:0]          kind;
      logic [LETTER_W-1:0] index;
      logic [LETTER_W-1:0] letter;
   } req_type;

   // Response payload.
   typedef struct packed {
      logic [LETTER_W-1:0] letter_out;
      logic                carry_out;
   } rsp_type;

   // Status from the core sequencer to the top level.
   typedef struct packed {
      logic                ready;
      logic                valid;
      logic [LETTER_W-1:0] letter;
      logic                carry;
   } core_status_type;

   // Core sequencer states.
   typedef enum logic [1:0] {
      CORE_IDLE,
      CORE_FORWARD,
      CORE_SEARCH,
      CORE_DONE
   } core_state_type;

endpackage

### rtl/enr_wiring_ram.sv
// ============================================================================
// Rotor wiring memory
// One write port and one registered read port holding the wiring offsets.
// ============================================================================
module enr_wiring_ram (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [enr_pkg::LETTER_W-1:0] wr_addr,
   input  logic [enr_pkg::LETTER_W-1:0] wr_data,
   input  logic [enr_pkg::LETTER_W-1:0] rd_addr,
   output logic [enr_pkg::LETTER_W-1:0] rd_data
);
   import enr_pkg::*;

   logic [LETTER_W-1:0] mem [ALPHABET_SIZE];
   logic [LETTER_W-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/enr_map_core.sv
// ============================================================================
// Rotor map sequencer
// Executes one request at a time against the wiring memory, keeps the rotor
// position and last output, and holds each result until the output takes it.
// ============================================================================
module enr_map_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_accept,
   input  enr_pkg::req_type              req_data,
   input  logic [enr_pkg::CSR_DATA_W-1:0] notch_mask,
   input  logic [enr_pkg::LETTER_W-1:0]  start_position,
   input  logic                          take,
   output enr_pkg::core_status_type      status
);
   import enr_pkg::*;

   // Reduce a value below twice the alphabet size into the alphabet.
   function automatic logic [LETTER_W-1:0] wrap_sum(input logic [LETTER_W:0] v);
      logic [LETTER_W:0] t;
      t = v - (LETTER_W+1)'(ALPHABET_SIZE);
      return (v >= (LETTER_W+1)'(ALPHABET_SIZE)) ? t[LETTER_W-1:0] : v[LETTER_W-1:0];
   endfunction

   // Advance a letter by one around the alphabet.
   function automatic logic [LETTER_W-1:0] inc_wrap(input logic [LETTER_W-1:0] v);
      return (v == LAST_LETTER) ? '0 : v + LETTER_W'(1);
   endfunction

   core_state_type      state_ff, state_in;
   logic [LETTER_W-1:0] position_ff, position_in;
   logic [LETTER_W-1:0] last_output_ff, last_output_in;
   logic                carry_ff, carry_in;
   logic [LETTER_W-1:0] letter_ff, letter_in;
   logic [LETTER_W-1:0] cmp_i_ff, cmp_i_in;
   logic [LETTER_W-1:0] slot_ff, slot_in;
   logic [LETTER_W-1:0] match_ff, match_in;
   logic                hit_ff, hit_in;

   logic                wr_en;
   logic [LETTER_W-1:0] wr_data;
   logic [LETTER_W-1:0] rd_addr;
   logic [LETTER_W-1:0] rd_data;

   logic [LETTER_W-1:0] req_letter;
   logic [LETTER_W-1:0] pos_next;
   logic [LETTER_W-1:0] fwd_slot;
   logic                search_hit;

   enr_wiring_ram u_wiring_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (req_data.index),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Request-side arithmetic, all mod the alphabet size.
   always_comb begin
      req_letter = wrap_sum({1'b0, req_data.letter});
      pos_next   = inc_wrap(position_ff);
      fwd_slot   = wrap_sum({1'b0, req_letter} + {1'b0, position_ff});
      wr_data    = wrap_sum({1'b0, req_letter} + (LETTER_W+1)'(ALPHABET_SIZE)
                            - {1'b0, req_data.index});
      search_hit = (wrap_sum({1'b0, cmp_i_ff} + {1'b0, rd_data}) == letter_ff);
   end

   // Next state and datapath control.
   always_comb begin
      state_in       = state_ff;
      position_in    = position_ff;
      last_output_in = last_output_ff;
      carry_in       = carry_ff;
      letter_in      = letter_ff;
      cmp_i_in       = cmp_i_ff;
      slot_in        = slot_ff;
      match_in       = match_ff;
      hit_in         = hit_ff;
      wr_en          = 1'b0;
      rd_addr        = slot_ff;
      status.ready   = 1'b0;
      status.valid   = 1'b0;
      status.letter  = last_output_ff;
      status.carry   = carry_ff;

      case (state_ff)
         CORE_IDLE: begin
            status.ready = 1'b1;
            if (req_accept) begin
               carry_in = 1'b0;
               state_in = CORE_DONE;
               case (req_data.kind)
                  KIND_LOAD: begin
                     wr_en = (req_data.index < LETTER_W'(ALPHABET_SIZE));
                  end
                  KIND_RESTART: begin
                     position_in = wrap_sum({1'b0, start_position});
                  end
                  KIND_STEP: begin
                     position_in = pos_next;
                     carry_in    = notch_mask[pos_next];
                  end
                  KIND_FORWARD: begin
                     rd_addr   = fwd_slot;
                     letter_in = req_letter;
                     state_in  = CORE_FORWARD;
                  end
                  KIND_BACKWARD: begin
                     // Entry i sits at slot (i + position); start at i = 0.
                     rd_addr   = position_ff;
                     slot_in   = pos_next;
                     cmp_i_in  = '0;
                     hit_in    = 1'b0;
                     letter_in = req_letter;
                     state_in  = CORE_SEARCH;
                  end
                  default: begin
                  end
               endcase
            end
         end

         CORE_FORWARD: begin
            last_output_in = wrap_sum({1'b0, letter_ff} + {1'b0, rd_data});
            state_in       = CORE_DONE;
         end

         CORE_SEARCH: begin
            // One entry compared per cycle while the next one is read.
            rd_addr  = slot_ff;
            slot_in  = inc_wrap(slot_ff);
            cmp_i_in = cmp_i_ff + LETTER_W'(1);
            if (search_hit) begin
               match_in = cmp_i_ff;
               hit_in   = 1'b1;
            end
            if (cmp_i_ff == LAST_LETTER) begin
               // The highest match wins; no match keeps the last output.
               if (search_hit) begin
                  last_output_in = cmp_i_ff;
               end else if (hit_ff) begin
                  last_output_in = match_ff;
               end
               state_in = CORE_DONE;
            end
         end

         CORE_DONE: begin
            status.valid = 1'b1;
            if (take) begin
               state_in = CORE_IDLE;
            end
         end

         default: begin
            state_in = CORE_IDLE;
         end
      endcase
   end

   // Control and architectural state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= CORE_IDLE;
         position_ff    <= '0;
         last_output_ff <= '0;
         carry_ff       <= 1'b0;
      end else begin
         state_ff       <= state_in;
         position_ff    <= position_in;
         last_output_ff <= last_output_in;
         carry_ff       <= carry_in;
      end
   end

   // Search working registers.
   always_ff @(posedge clock) begin
      letter_ff <= letter_in;
      cmp_i_ff  <= cmp_i_in;
      slot_ff   <= slot_in;
      match_ff  <= match_in;
      hit_ff    <= hit_in;
   end

endmodule

### rtl/enigma_rotor_step_and_map_unit.sv
// ============================================================================
// Rotor step and map unit
// Flow: load, restart, step and unknown kinds go straight to the done state, a
// forward map first reads the wiring memory, and a backward map walks all 26
// wiring entries through the single read port of the memory for its result.
// One request at a time: a new request is taken only once the result has moved
// to the output register, which waits while the receiver stalls.
// Reset: synchronous; position, last output, carry and configuration registers
// clear to zero, wiring memory is undefined until loaded.
// ============================================================================
module enigma_rotor_step_and_map_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  enr_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output enr_pkg::rsp_type                  rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [enr_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [enr_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import enr_pkg::*;

   logic [CSR_DATA_W-1:0] notch_mask_ff;
   logic [LETTER_W-1:0]   start_position_ff;
   logic                  rsp_valid_ff;
   rsp_type               rsp_data_ff;
   core_status_type       core_status;
   logic                  take;
   logic                  req_accept;

   // Configuration registers; writes are always taken.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         notch_mask_ff     <= '0;
         start_position_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_NOTCH_MASK:     notch_mask_ff     <= csr_wdata;
            CSR_START_POSITION: start_position_ff <= csr_wdata[LETTER_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Request handshake.
   assign req_stall  = !core_status.ready;
   assign req_accept = req_valid && core_status.ready;

   enr_map_core u_map_core (
      .clock          (clock),
      .reset          (reset),
      .req_accept     (req_accept),
      .req_data       (req_data),
      .notch_mask     (notch_mask_ff),
      .start_position (start_position_ff),
      .take           (take),
      .status         (core_status)
   );

   // Output register; takes a result when empty or being drained.
   assign take = core_status.valid && (!rsp_valid_ff || !rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (take) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_data_ff.letter_out <= core_status.letter;
         rsp_data_ff.carry_out  <= core_status.carry;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // The core never asks for a request while it holds a result.
   assert property (@(posedge clock) disable iff (reset)
      !(core_status.ready && core_status.valid))
      else $error("core ready while holding a result");

   // An accepted request makes the block busy on the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_accept |=> req_stall)
      else $error("request accepted while still busy");

   // A result moved to the output register is released by the core.
   assert property (@(posedge clock) disable iff (reset)
      take |=> !core_status.valid)
      else $error("core result delivered twice");

endmodule

### sim/enigma_rotor_step_and_map_unit_test.sv
`timescale 1ns / 1ps
// ============================================================================
// Rotor step and map unit testbench
// Sends load, restart, step, map and unused-kind requests through the
// valid/stall channel under bursty traffic and random response stalls. The
// bench carries its own model of the rotor state and checks every response,
// field by field, against it.
// ============================================================================
module enigma_rotor_step_and_map_unit_test;
   import enr_pkg::*;

   localparam int CLOCK_PERIOD     = 4;
   localparam int RESET_CYCLES     = 12;
   localparam int PHASE_COUNT      = 8;
   localparam int PHASE_REQUESTS   = 220;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int SETTLE_CYCLES    = 40;
   localparam int CYCLE_LIMIT      = 2000000;
   localparam int MAX_REPORTS      = 50;
   localparam int PREDICTED        = -1;

   // Request kinds that the block does not define.
   localparam logic [2:0] KIND_SPARE_5 = 3'd5;
   localparam logic [2:0] KIND_SPARE_6 = 3'd6;
   localparam logic [2:0] KIND_SPARE_7 = 3'd7;

   // Register indexes beyond the defined list.
   localparam logic [CSR_INDEX_W-1:0] CSR_FIRST_UNUSED = 4'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_LAST_UNUSED  = 4'd15;

   typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_pattern_type;

   typedef struct {
      req_type req;
      bit      typed;
      rsp_type want;
   } stimulus_row_type;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_type                req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // Rotor state as the bench expects it.
   logic [LETTER_W-1:0]   wiring_offset [ALPHABET_SIZE];
   logic [LETTER_W-1:0]   rotor_position = '0;
   logic [LETTER_W-1:0]   last_letter    = '0;
   logic [CSR_DATA_W-1:0] notch_bits     = '0;
   logic [LETTER_W-1:0]   start_letter   = '0;

   rsp_type          rotor_outputs_due [$];
   stimulus_row_type stimulus_table [$];
   int               mismatch_count = 0;
   int               cycle_count    = 0;
   bit               hold_request   = 1'b0;

   enigma_rotor_step_and_map_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin : clock_gen
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // The run ends here if the responses stop coming.
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("TB_ERROR");
      $finish;
   end

   function automatic int wrap_letter(int v);
      return v % ALPHABET_SIZE;
   endfunction

   // Right-to-left path through the wiring at the current rotor position.
   function automatic int rotor_forward(int c);
      int slot;
      slot = wrap_letter(c + int'(rotor_position));
      return wrap_letter(c + int'(wiring_offset[slot]));
   endfunction

   // Applies one request to the expected rotor state and returns its response.
   function automatic rsp_type rotor_advance(req_type r);
      rsp_type result;
      int      c;
      int      i;
      c = wrap_letter(int'(r.letter));
      result.carry_out = 1'b0;
      case (r.kind)
         KIND_LOAD: begin
            if (r.index < ALPHABET_SIZE)
               wiring_offset[r.index] =
                  LETTER_W'(wrap_letter(c + ALPHABET_SIZE - int'(r.index)));
         end
         KIND_RESTART: begin
            rotor_position = LETTER_W'(wrap_letter(int'(start_letter)));
         end
         KIND_STEP: begin
            rotor_position   = LETTER_W'(wrap_letter(int'(rotor_position) + 1));
            result.carry_out = notch_bits[rotor_position];
         end
         KIND_FORWARD: begin
            last_letter = LETTER_W'(rotor_forward(c));
         end
         KIND_BACKWARD: begin
            // The highest matching contact wins; no match keeps the last letter.
            for (i = 0; i < ALPHABET_SIZE; i++)
               if (rotor_forward(i) == c) last_letter = LETTER_W'(i);
         end
         default: begin
         end
      endcase
      result.letter_out = last_letter;
      return result;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      if (mismatch_count < MAX_REPORTS)
         $display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
      mismatch_count++;
   endtask

   // Register writes happen only while no response is outstanding.
   task automatic csr_write(input logic [CSR_INDEX_W-1:0] reg_index,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= reg_index;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      if (reg_index == CSR_NOTCH_MASK)
         notch_bits = data;
      else if (reg_index == CSR_START_POSITION)
         start_letter = data[LETTER_W-1:0];
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Offers one request and queues its response once the block takes it.
   task automatic send_request(input req_type r, input bit typed, input rsp_type want);
      rsp_type predicted;
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      predicted = rotor_advance(r);
      rotor_outputs_due.push_back(typed ? want : predicted);
   endtask

   task automatic idle_sender(input int cycles);
      if (cycles > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (cycles - 1) @(negedge clock);
      end
   endtask

   task automatic wait_all_responses();
      @(negedge clock);
      req_valid <= 1'b0;
      while (rotor_outputs_due.size() != 0) @(posedge clock);
   endtask

   task automatic add_row(input logic [2:0] kind, input int idx, input int letter,
                          input int want_letter, input bit want_carry);
      stimulus_row_type row;
      row.req.kind        = kind;
      row.req.index       = LETTER_W'(idx);
      row.req.letter      = LETTER_W'(letter);
      row.typed           = (want_letter >= 0);
      row.want.letter_out = LETTER_W'(want_letter);
      row.want.carry_out  = want_carry;
      stimulus_table.push_back(row);
   endtask

   task automatic walk_table();
      stimulus_row_type row;
      while (stimulus_table.size() != 0) begin
         row = stimulus_table.pop_front();
         send_request(row.req, row.typed, row.want);
      end
   endtask

   // Mostly well-formed rotor traffic, with some ignored loads and unused kinds.
   function automatic req_type random_request();
      req_type r;
      int      pick;
      r.index  = LETTER_W'($urandom_range(0, 31));
      r.letter = LETTER_W'($urandom_range(0, 31));
      pick     = $urandom_range(0, 99);
      if (pick < 25)
         r.kind = KIND_STEP;
      else if (pick < 50)
         r.kind = KIND_FORWARD;
      else if (pick < 70)
         r.kind = KIND_BACKWARD;
      else if (pick < 78)
         r.kind = KIND_RESTART;
      else if (pick < 90) begin
         r.kind  = KIND_LOAD;
         r.index = LETTER_W'($urandom_range(0, ALPHABET_SIZE - 1));
      end else if (pick < 95) begin
         r.kind  = KIND_LOAD;
         r.index = LETTER_W'($urandom_range(ALPHABET_SIZE, 31));
      end else
         r.kind = 3'($urandom_range(KIND_SPARE_5, KIND_SPARE_7));
      return r;
   endfunction

   // Sends requests in bursts. A hold point asks the receiver for a long stall,
   // and a drain point makes the sender wait for every outstanding response.
   task automatic run_random_phase(input int count, input bit gaps_on,
                                   input int hold_at, input int drain_at);
      int sent;
      int burst;
      sent = 0;
      while (sent < count) begin
         burst = $urandom_range(1, 40);
         while (burst > 0 && sent < count) begin
            if (sent == hold_at) hold_request = 1'b1;
            if (sent == drain_at) wait_all_responses();
            send_request(random_request(), 1'b0, '0);
            sent++;
            burst--;
         end
         if (gaps_on && $urandom_range(0, 3) != 0) idle_sender($urandom_range(1, 12));
      end
   endtask

   // Receiver stall patterns, with a long hold when the sender asks for one.
   initial begin : receiver
      stall_pattern_type pattern;
      int                run;
      int                i;
      wait (!reset);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            for (i = 0; i < LONG_HOLD_CYCLES; i++) begin
               @(negedge clock);
               rsp_stall <= 1'b1;
            end
         end else begin
            pattern = stall_pattern_type'($urandom_range(0, 3));
            run     = $urandom_range(1, 60);
            for (i = 0; i < run; i++) begin
               @(negedge clock);
               case (pattern)
                  STALL_NONE:  rsp_stall <= 1'b0;
                  STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
                  STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
                  default:     rsp_stall <= ~rsp_stall;
               endcase
            end
         end
      end
   end

   // Each accepted response is compared with the oldest expected one.
   always @(posedge clock) begin : response_check
      rsp_type due;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (rotor_outputs_due.size() == 0)
            report_mismatch("response with no request outstanding",
                            int'(rsp_data.letter_out), PREDICTED);
         else begin
            due = rotor_outputs_due.pop_front();
            if (rsp_data.letter_out !== due.letter_out)
               report_mismatch("letter_out", int'(rsp_data.letter_out),
                               int'(due.letter_out));
            if (rsp_data.carry_out !== due.carry_out)
               report_mismatch("carry_out", int'(rsp_data.carry_out),
                               int'(due.carry_out));
         end
      end
   end

   initial begin : stimulus
      int                    wired_letter [ALPHABET_SIZE];
      int                    i;
      int                    j;
      int                    swap;
      int                    p;
      logic [CSR_DATA_W-1:0] notch_setting;
      logic [LETTER_W-1:0]   start_setting;
      logic [CSR_DATA_W-1:0] start_data;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Straight after reset: nothing reads the wiring, everything reads zero.
      add_row(KIND_SPARE_5, 31, 31, 0, 1'b0);
      add_row(KIND_SPARE_6, 0, 0, 0, 1'b0);
      add_row(KIND_SPARE_7, 21, 10, 0, 1'b0);
      add_row(KIND_STEP, 0, 0, 0, 1'b0);
      add_row(KIND_RESTART, 31, 31, 0, 1'b0);
      add_row(KIND_LOAD, ALPHABET_SIZE, 3, 0, 1'b0);
      add_row(KIND_LOAD, 31, 31, 0, 1'b0);
      walk_table();
      wait_all_responses();

      csr_write(CSR_NOTCH_MASK, '1);
      csr_write(CSR_START_POSITION, CSR_DATA_W'(LAST_LETTER));
      csr_write(CSR_LAST_UNUSED, '1);

      // Fill every wiring entry from a shuffled alphabet before any map.
      for (i = 0; i < ALPHABET_SIZE; i++) wired_letter[i] = i;
      for (i = ALPHABET_SIZE - 1; i > 0; i--) begin
         j               = $urandom_range(0, i);
         swap            = wired_letter[i];
         wired_letter[i] = wired_letter[j];
         wired_letter[j] = swap;
      end
      for (i = 0; i < ALPHABET_SIZE; i++)
         add_row(KIND_LOAD, i,
                 wired_letter[i] + ((wired_letter[i] < 32 - ALPHABET_SIZE &&
                                     $urandom_range(0, 1) == 1) ? ALPHABET_SIZE : 0),
                 PREDICTED, 1'b0);
      walk_table();

      // Restart to the last position, then step across the wrap onto a notch.
      add_row(KIND_RESTART, 0, 0, 0, 1'b0);
      add_row(KIND_STEP, 0, 0, 0, 1'b1);
      add_row(KIND_FORWARD, 0, 0, PREDICTED, 1'b0);
      add_row(KIND_FORWARD, 0, 25, PREDICTED, 1'b0);
      add_row(KIND_FORWARD, 31, 31, PREDICTED, 1'b0);
      add_row(KIND_BACKWARD, 0, 0, PREDICTED, 1'b0);
      add_row(KIND_BACKWARD, 0, 25, PREDICTED, 1'b0);
      add_row(KIND_BACKWARD, 31, 30, PREDICTED, 1'b0);
      // Duplicate a wired letter: one letter loses its match, another gets two.
      add_row(KIND_LOAD, 0, wired_letter[1], PREDICTED, 1'b0);
      add_row(KIND_BACKWARD, 0, wired_letter[0], PREDICTED, 1'b0);
      add_row(KIND_BACKWARD, 0, wired_letter[1], PREDICTED, 1'b0);
      add_row(KIND_LOAD, 0, wired_letter[0], PREDICTED, 1'b0);
      add_row(KIND_SPARE_7, 31, 31, PREDICTED, 1'b0);
      add_row(KIND_STEP, 0, 0, PREDICTED, 1'b0);
      walk_table();

      // Random phases, each under its own register setting.
      for (p = 0; p < PHASE_COUNT; p++) begin
         wait_all_responses();
         notch_setting = CSR_DATA_W'($urandom);
         start_setting = LETTER_W'($urandom_range(0, 31));
         case (p)
            0: begin
               notch_setting = '0;
               start_setting = '0;
            end
            1: begin
               notch_setting = '1;
               start_setting = LAST_LETTER;
            end
            2: start_setting = 5'd31;
            3: begin
               notch_setting = CSR_DATA_W'(1);
               start_setting = 5'd26;
            end
            4: notch_setting = CSR_DATA_W'(1) << (ALPHABET_SIZE - 1);
            default: begin
            end
         endcase
         start_data                 = CSR_DATA_W'($urandom);
         start_data[LETTER_W-1:0]   = start_setting;
         csr_write(CSR_NOTCH_MASK, notch_setting);
         csr_write(CSR_START_POSITION, start_data);
         csr_write(CSR_INDEX_W'($urandom_range(CSR_FIRST_UNUSED, CSR_LAST_UNUSED)),
                   CSR_DATA_W'($urandom));
         run_random_phase(PHASE_REQUESTS, p != 1,
                          (p == 3) ? 60 : PREDICTED,
                          (p == 5) ? 110 : PREDICTED);
      end

      wait_all_responses();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

### filelist.f
rtl/enr_pkg.sv
rtl/enr_wiring_ram.sv
rtl/enr_map_core.sv
rtl/enigma_rotor_step_and_map_unit.sv
sim/enigma_rotor_step_and_map_unit_test.sv
